// ----- sv/shs_pkg.sv -----
// Package with codes, register defaults and the result layout of the homing sequencer.
`default_nettype none

package shs_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned CmdW      = 2;
  localparam int unsigned DirW      = 2;
  localparam int unsigned NowW      = 32;
  localparam int unsigned LoadW     = 10;
  localparam int unsigned PosW      = 32;
  localparam int unsigned MoveW     = 21;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  // Register widths.
  localparam int unsigned ConfirmW  = 8;
  localparam int unsigned TimeoutW  = 32;
  localparam int unsigned StepsW    = 20;
  localparam int unsigned PollW     = 16;
  localparam int unsigned ZeroRunW  = 8;
  localparam int unsigned MatchRunW = 2;

  // Default width of the stored timestamps.
  localparam int unsigned TimeBitsDefault = 32;

  // Register reset values.
  localparam logic [ConfirmW-1:0] ConfirmRst       = 8'd8;
  localparam logic [TimeoutW-1:0] RunTimeoutRst    = 32'd30000;
  localparam logic [TimeoutW-1:0] BackTimeoutRst   = 32'd10000;
  localparam logic [StepsW-1:0]   BackStepsRst     = 20'd2048;
  localparam logic [PollW-1:0]    SeekPollRst      = 16'd2;
  localparam logic [PollW-1:0]    BackPollRst      = 16'd10;

  // Saturation limits of the run counters.
  localparam logic [ZeroRunW-1:0]  ZeroRunMax  = '1;
  localparam logic [MatchRunW-1:0] MatchRunMax = '1;
  localparam logic [MatchRunW-1:0] MatchNeeded = 2'd2;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_CONFIRM_COUNT  = 3'd0,
    REG_RUN_TIMEOUT    = 3'd1,
    REG_BACK_TIMEOUT   = 3'd2,
    REG_BACKOFF_STEPS  = 3'd3,
    REG_SEEK_POLL      = 3'd4,
    REG_BACK_POLL      = 3'd5
  } reg_idx_e;

  // Request commands.
  typedef enum logic [CmdW-1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_TAKE  = 2'd2
  } cmd_e;

  // Seek directions.
  localparam logic [DirW-1:0] DIR_POS = 2'd0;
  localparam logic [DirW-1:0] DIR_NEG = 2'd1;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEEK = 3'd1,
    PH_BACK = 3'd2,
    PH_DONE = 3'd3,
    PH_FAIL = 3'd4
  } phase_e;

  // Reply codes: start replies and take replies share the field.
  localparam logic [1:0] RPL_STARTED = 2'd0;
  localparam logic [1:0] RPL_BUSY    = 2'd1;
  localparam logic [1:0] RPL_INVALID = 2'd2;
  localparam logic [1:0] RPL_SUCCESS = 2'd0;
  localparam logic [1:0] RPL_FAIL    = 2'd1;
  localparam logic [1:0] RPL_NONE    = 2'd0;

  // Velocity commands.
  localparam logic [1:0] VEL_NONE = 2'd0;
  localparam logic [1:0] VEL_POS  = 2'd1;
  localparam logic [1:0] VEL_NEG  = 2'd2;

  // Completion messages.
  localparam logic [1:0] FB_NONE  = 2'd0;
  localparam logic [1:0] FB_DONE  = 2'd1;
  localparam logic [1:0] FB_STALL = 2'd2;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]       feedback;
    logic             restore_settings;
    logic             zero_position;
    logic [MoveW-1:0] move_relative;
    logic             stop_motor;
    logic [1:0]       drive_velocity;
    logic             configure_detect;
    logic             motor_out;
    logic [2:0]       phase;
    logic [1:0]       reply_code;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/sensorless_homing_sequencer.sv -----
// Sensorless homing sequencer: stall-detect homing with seek, backoff and zeroing.
//
// Requests arrive on the s_axis channel; the command travels in s_axis_tuser and
// the remaining fields in s_axis_tdata. Every request yields exactly one result
// on the m_axis channel, carrying the reply, the phase after the request and the
// motor actions to apply.
// The result is registered: a request's result shows on m_axis in the cycle after
// the request is accepted. Throughput is one request per cycle while the receiver
// takes results; the phase logic and the timestamp compares settle in one pass
// from the request port to the result register.
// The result register is the only buffer. s_axis_tready stays high while it is
// empty or being taken, so a stalled receiver holds back new requests only while
// a result is waiting.
// Reset empties the result register, returns to the idle phase with a failed outcome
// and loads the configuration registers with their defaults. The user writes registers
// via cfg_we_i, cfg_idx_i and cfg_wdata_i only while idle; this is not enforced.
`default_nettype none

module sensorless_homing_sequencer #(
  parameter int unsigned TIME_BITS = shs_pkg::TimeBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Request channel.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: motor_select, motor_present, direction, now_ms,
  // stall_event, load_value, position, zero fill.
  input  wire logic [shs_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: command.
  input  wire logic [shs_pkg::CmdW-1:0]       s_axis_tuser,
  // Result channel.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata from bit 0: reply_code, phase, motor_out, configure_detect,
  // drive_velocity, stop_motor, move_relative, zero_position,
  // restore_settings, feedback, zero fill.
  output logic [shs_pkg::OutDataW-1:0]        m_axis_tdata,
  // Configuration write port.
  input  wire logic                           cfg_we_i,
  input  wire logic [shs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [shs_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import shs_pkg::*;

  // Compare width covers both the timestamps and the 32-bit timeouts.
  localparam int unsigned CmpW = (TIME_BITS > TimeoutW) ? TIME_BITS : TimeoutW;
  localparam int unsigned ExtW = (TIME_BITS > NowW) ? TIME_BITS : NowW;

  // Request fields.
  logic                    in_fire;
  cmd_e                    cmd;
  logic                    motor_select;
  logic                    motor_present;
  logic [DirW-1:0]         direction;
  logic [NowW-1:0]         now_ms;
  logic                    stall_event;
  logic [LoadW-1:0]        load_value;
  logic [PosW-1:0]         position;

  assign cmd           = cmd_e'(s_axis_tuser);
  assign motor_select  = s_axis_tdata[0];
  assign motor_present = s_axis_tdata[1];
  assign direction     = s_axis_tdata[3:2];
  assign now_ms        = s_axis_tdata[35:4];
  assign stall_event   = s_axis_tdata[36];
  assign load_value    = s_axis_tdata[46:37];
  assign position      = s_axis_tdata[78:47];

  // Configuration registers.
  logic [ConfirmW-1:0] confirm_count_q;
  logic [TimeoutW-1:0] run_timeout_q;
  logic [TimeoutW-1:0] back_timeout_q;
  logic [StepsW-1:0]   backoff_steps_q;
  logic [PollW-1:0]    seek_poll_q;
  logic [PollW-1:0]    back_poll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_count_q <= ConfirmRst;
      run_timeout_q   <= RunTimeoutRst;
      back_timeout_q  <= BackTimeoutRst;
      backoff_steps_q <= BackStepsRst;
      seek_poll_q     <= SeekPollRst;
      back_poll_q     <= BackPollRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CONFIRM_COUNT: confirm_count_q <= cfg_wdata_i[ConfirmW-1:0];
        REG_RUN_TIMEOUT:   run_timeout_q   <= cfg_wdata_i[TimeoutW-1:0];
        REG_BACK_TIMEOUT:  back_timeout_q  <= cfg_wdata_i[TimeoutW-1:0];
        REG_BACKOFF_STEPS: backoff_steps_q <= cfg_wdata_i[StepsW-1:0];
        REG_SEEK_POLL:     seek_poll_q     <= cfg_wdata_i[PollW-1:0];
        REG_BACK_POLL:     back_poll_q     <= cfg_wdata_i[PollW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  phase_e                 phase_q, phase_d;
  logic                   motor_q, motor_d;
  logic                   seek_neg_q, seek_neg_d;
  logic [ZeroRunW-1:0]    zero_run_q, zero_run_d;
  logic [MatchRunW-1:0]   match_run_q, match_run_d;
  logic [TIME_BITS-1:0]   last_poll_q, last_poll_d;
  logic [TIME_BITS-1:0]   start_time_q, start_time_d;
  logic [PosW-1:0]        target_q, target_d;
  logic                   failed_q, failed_d;

  // Timestamp of the request, taken modulo 2^TIME_BITS.
  logic [ExtW-1:0]        now_ext;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   since_start;
  logic [TIME_BITS-1:0]   since_poll;
  logic [CmpW-1:0]        since_start_c;
  logic [CmpW-1:0]        since_poll_c;

  assign now_ext       = ExtW'(now_ms);
  assign now_t         = now_ext[TIME_BITS-1:0];
  assign since_start   = now_t - start_time_q;
  assign since_poll    = now_t - last_poll_q;
  assign since_start_c = CmpW'(since_start);
  assign since_poll_c  = CmpW'(since_poll);

  // Backoff move, opposite to the seek direction.
  logic [PosW-1:0]        move_amt;
  logic [ZeroRunW-1:0]    zero_run_inc;
  logic [MatchRunW-1:0]   match_run_inc;

  assign move_amt      = seek_neg_q ? PosW'(backoff_steps_q)
                                    : PosW'(0) - PosW'(backoff_steps_q);
  assign zero_run_inc  = (zero_run_q < ZeroRunMax) ? zero_run_q + ZeroRunW'(1)
                                                   : zero_run_q;
  assign match_run_inc = (match_run_q < MatchRunMax) ? match_run_q + MatchRunW'(1)
                                                     : match_run_q;

  result_t res;
  logic    active;
  logic    backoff_go;

  assign active = (phase_q == PH_SEEK) || (phase_q == PH_BACK);

  // Next state and result of the accepted request.
  always_comb begin
    phase_d      = phase_q;
    motor_d      = motor_q;
    seek_neg_d   = seek_neg_q;
    zero_run_d   = zero_run_q;
    match_run_d  = match_run_q;
    last_poll_d  = last_poll_q;
    start_time_d = start_time_q;
    target_d     = target_q;
    failed_d     = failed_q;
    backoff_go   = 1'b0;
    res          = '0;

    if (in_fire) begin
      unique case (cmd)
        CMD_START: begin
          if (active) begin
            res.reply_code = RPL_BUSY;
          end else if (!motor_present || (direction != DIR_POS && direction != DIR_NEG)) begin
            res.reply_code = RPL_INVALID;
          end else begin
            res.reply_code       = RPL_STARTED;
            motor_d              = motor_select;
            seek_neg_d           = direction[0];
            zero_run_d           = '0;
            res.configure_detect = 1'b1;
            res.drive_velocity   = direction[0] ? VEL_NEG : VEL_POS;
            last_poll_d          = now_t;
            start_time_d         = now_t;
            phase_d              = PH_SEEK;
          end
        end
        CMD_TICK: begin
          if (!active) begin
            // Nothing to poll outside seek and backoff.
          end else if (!motor_present) begin
            // Driver gone: fail without touching it.
            phase_d      = PH_FAIL;
            failed_d     = 1'b1;
            res.feedback = FB_STALL;
          end else if (phase_q == PH_SEEK) begin
            if (since_start_c >= CmpW'(run_timeout_q)) begin
              res.stop_motor       = 1'b1;
              res.restore_settings = 1'b1;
              phase_d              = PH_FAIL;
              failed_d             = 1'b1;
              res.feedback         = FB_STALL;
            end else if (since_poll_c >= CmpW'(seek_poll_q)) begin
              last_poll_d = now_t;
              if (stall_event) begin
                backoff_go = 1'b1;
              end else if (load_value == '0) begin
                zero_run_d = zero_run_inc;
                backoff_go = (zero_run_inc >= confirm_count_q);
              end else begin
                zero_run_d = '0;
              end
            end
          end else begin
            if (since_start_c >= CmpW'(back_timeout_q)) begin
              res.stop_motor       = 1'b1;
              res.restore_settings = 1'b1;
              phase_d              = PH_FAIL;
              failed_d             = 1'b1;
              res.feedback         = FB_STALL;
            end else if (since_poll_c >= CmpW'(back_poll_q)) begin
              last_poll_d = now_t;
              if (position == target_q) begin
                match_run_d = match_run_inc;
                if (match_run_inc >= MatchNeeded) begin
                  res.zero_position    = 1'b1;
                  res.stop_motor       = 1'b1;
                  res.restore_settings = 1'b1;
                  phase_d              = PH_DONE;
                  failed_d             = 1'b0;
                  res.feedback         = FB_DONE;
                end
              end else begin
                match_run_d = '0;
              end
            end
          end
        end
        CMD_TAKE: begin
          res.reply_code = failed_q ? RPL_FAIL : RPL_SUCCESS;
          if (phase_q == PH_DONE || phase_q == PH_FAIL) begin
            phase_d  = PH_IDLE;
            failed_d = 1'b1;
          end
        end
        default: begin
          res.reply_code = RPL_NONE;
        end
      endcase

      // Stall confirmed: stop and move back off the limit.
      if (backoff_go) begin
        res.stop_motor    = 1'b1;
        res.move_relative = move_amt[MoveW-1:0];
        target_d          = position + move_amt;
        match_run_d       = '0;
        start_time_d      = now_t;
        phase_d           = PH_BACK;
      end
    end

    res.phase     = phase_d;
    res.motor_out = motor_d;
  end

  // Result register with its valid flag.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      phase_q      <= PH_IDLE;
      motor_q      <= 1'b0;
      seek_neg_q   <= 1'b0;
      zero_run_q   <= '0;
      match_run_q  <= '0;
      last_poll_q  <= '0;
      start_time_q <= '0;
      target_q     <= '0;
      failed_q     <= 1'b1;
    end else begin
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      phase_q      <= phase_d;
      motor_q      <= motor_d;
      seek_neg_q   <= seek_neg_d;
      zero_run_q   <= zero_run_d;
      match_run_q  <= match_run_d;
      last_poll_q  <= last_poll_d;
      start_time_q <= start_time_d;
      target_q     <= target_d;
      failed_q     <= failed_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= OutDataW'(res);
    end
  end

endmodule

`default_nettype wire
